// ===== rtl/wfs_pkg.sv =====
`default_nettype none

package wfs_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    localparam logic [1:0] REG_HEADER   = 2'd0;
    localparam logic [1:0] REG_ADDRESS  = 2'd1;
    localparam logic [1:0] REG_FUNCTION = 2'd2;

    localparam logic [7:0] HEADER_RESET   = 8'hAA;
    localparam logic [7:0] ADDRESS_RESET  = 8'hFF;
    localparam logic [7:0] FUNCTION_RESET = 8'hF1;

    typedef struct packed {
        logic signed [31:0] data_word;
        logic [5:0]         word_count;
    } wfs_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } wfs_out_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] target_address;
        logic [7:0] frame_function;
    } wfs_cfg_t;

    typedef struct packed {
        logic [31:0] word;
        logic        first;
        logic        last;
        logic [7:0]  header_byte;
        logic [7:0]  target_address;
        logic [7:0]  frame_function;
        logic [7:0]  length_byte;
    } wfs_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } wfs_qstat_t;

    typedef enum logic [3:0] {
        ST_HDR,
        ST_ADDR,
        ST_FUNC,
        ST_LEN,
        ST_D0,
        ST_D1,
        ST_D2,
        ST_D3,
        ST_SUM,
        ST_ADD
    } step_t;

endpackage

`default_nettype wire

// ===== rtl/wfs_front.sv =====
`default_nettype none

module wfs_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              word_valid,
    output logic                   word_stall,
    input  wire wfs_pkg::wfs_in_t  word_data,
    input  wire wfs_pkg::wfs_cfg_t cfg,
    input  wire wfs_pkg::wfs_qstat_t qstat,
    output logic                   push,
    output wfs_pkg::wfs_cmd_t      cmd
);

    logic [5:0] words_left_reg;
    logic [5:0] words_left_next;
    logic       accept;
    logic       opening;
    logic       drop;

    assign word_stall = qstat.full;
    assign accept     = word_valid && !word_stall;
    assign opening    = (words_left_reg == 6'd0);
    assign drop       = opening && (word_data.word_count == 6'd0);
    assign push       = accept && !drop;

    always_comb
    begin
        cmd.word           = word_data.data_word;
        cmd.first          = opening;
        cmd.header_byte    = cfg.header_byte;
        cmd.target_address = cfg.target_address;
        cmd.frame_function = cfg.frame_function;
        cmd.length_byte    = {word_data.word_count, 2'b00};
        if (opening)
        begin
            cmd.last        = (word_data.word_count == 6'd1);
            words_left_next = word_data.word_count - 6'd1;
        end
        else
        begin
            cmd.last        = (words_left_reg == 6'd1);
            words_left_next = words_left_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_left_reg <= 6'd0;
        end
        else if (push)
        begin
            words_left_reg <= words_left_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wfs_queue.sv =====
`default_nettype none

module wfs_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire wfs_pkg::wfs_cmd_t  push_cmd,
    input  wire logic               pop,
    output wfs_pkg::wfs_cmd_t       head,
    output wfs_pkg::wfs_qstat_t     qstat
);

    wfs_pkg::wfs_cmd_t                mem [wfs_pkg::QUEUE_DEPTH];
    logic [wfs_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [wfs_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [wfs_pkg::QUEUE_AW:0]       count_reg;
    logic [wfs_pkg::QUEUE_AW:0]       count_next;

    assign head        = mem[rd_ptr_reg];
    assign qstat.full  = (count_reg == (wfs_pkg::QUEUE_AW+1)'(wfs_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wfs_back.sv =====
`default_nettype none

module wfs_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wfs_pkg::wfs_cmd_t   head,
    input  wire wfs_pkg::wfs_qstat_t qstat,
    output logic                     pop,
    output logic                     byte_valid,
    input  wire logic                byte_stall,
    output wfs_pkg::wfs_out_t        byte_data
);

    wfs_pkg::step_t    step_reg;
    wfs_pkg::step_t    step_next;
    wfs_pkg::step_t    cur_step;
    logic              advance;
    logic              done;
    logic [7:0]        byte_val;
    logic              end_flag;
    logic              checked;
    logic [7:0]        sum_base;
    logic [7:0]        add_base;
    logic [7:0]        sum_reg;
    logic [7:0]        sum_next;
    logic [7:0]        add_reg;
    logic [7:0]        add_next;
    logic              out_valid_reg;
    wfs_pkg::wfs_out_t out_data_reg;

    assign advance  = !qstat.empty && (!out_valid_reg || !byte_stall);
    assign cur_step = (step_reg == wfs_pkg::ST_HDR && !head.first) ? wfs_pkg::ST_D0 : step_reg;
    assign pop      = advance && done;

    // next step
    always_comb
    begin
        step_next = step_reg;
        done      = 1'b0;
        case (cur_step)
            wfs_pkg::ST_HDR:  step_next = wfs_pkg::ST_ADDR;
            wfs_pkg::ST_ADDR: step_next = wfs_pkg::ST_FUNC;
            wfs_pkg::ST_FUNC: step_next = wfs_pkg::ST_LEN;
            wfs_pkg::ST_LEN:  step_next = wfs_pkg::ST_D0;
            wfs_pkg::ST_D0:   step_next = wfs_pkg::ST_D1;
            wfs_pkg::ST_D1:   step_next = wfs_pkg::ST_D2;
            wfs_pkg::ST_D2:   step_next = wfs_pkg::ST_D3;
            wfs_pkg::ST_D3:
            begin
                if (head.last)
                begin
                    step_next = wfs_pkg::ST_SUM;
                end
                else
                begin
                    step_next = wfs_pkg::ST_HDR;
                    done      = 1'b1;
                end
            end
            wfs_pkg::ST_SUM:  step_next = wfs_pkg::ST_ADD;
            wfs_pkg::ST_ADD:
            begin
                step_next = wfs_pkg::ST_HDR;
                done      = 1'b1;
            end
            default:
            begin
                step_next = wfs_pkg::ST_HDR;
                done      = 1'b1;
            end
        endcase
    end

    // byte for the current step
    always_comb
    begin
        byte_val = 8'd0;
        end_flag = 1'b0;
        checked  = 1'b1;
        case (cur_step)
            wfs_pkg::ST_HDR:  byte_val = head.header_byte;
            wfs_pkg::ST_ADDR: byte_val = head.target_address;
            wfs_pkg::ST_FUNC: byte_val = head.frame_function;
            wfs_pkg::ST_LEN:  byte_val = head.length_byte;
            wfs_pkg::ST_D0:   byte_val = head.word[7:0];
            wfs_pkg::ST_D1:   byte_val = head.word[15:8];
            wfs_pkg::ST_D2:   byte_val = head.word[23:16];
            wfs_pkg::ST_D3:   byte_val = head.word[31:24];
            wfs_pkg::ST_SUM:
            begin
                byte_val = sum_reg;
                checked  = 1'b0;
            end
            wfs_pkg::ST_ADD:
            begin
                byte_val = add_reg;
                end_flag = 1'b1;
                checked  = 1'b0;
            end
            default:
            begin
                byte_val = 8'd0;
                checked  = 1'b0;
            end
        endcase
    end

    // running checks restart on the header byte
    assign sum_base = (cur_step == wfs_pkg::ST_HDR) ? 8'd0 : sum_reg;
    assign add_base = (cur_step == wfs_pkg::ST_HDR) ? 8'd0 : add_reg;
    assign sum_next = sum_base + byte_val;
    assign add_next = add_base + sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= wfs_pkg::ST_HDR;
            out_valid_reg <= 1'b0;
            sum_reg       <= 8'd0;
            add_reg       <= 8'd0;
        end
        else
        begin
            if (advance)
            begin
                step_reg      <= step_next;
                out_valid_reg <= 1'b1;
                if (checked)
                begin
                    sum_reg <= sum_next;
                    add_reg <= add_next;
                end
            end
            else if (!byte_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.out_byte  <= byte_val;
            out_data_reg.frame_end <= end_flag;
        end
    end

    assign byte_valid = out_valid_reg;
    assign byte_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/word_frame_sum_add_check_encoder_core.sv =====
// channel  | direction | handshake              | payload
// word     | in        | word_valid, word_stall | word_data (data_word, word_count)
// byte     | out       | byte_valid, byte_stall | byte_data (out_byte, frame_end)
// config   | in        | apb psel/penable/...   | pwdata, prdata
//
// one output byte per cycle from a single output register while the queue is not empty and
// byte_stall is low; a middle word gives 4 bytes, a first 8, a last 6, a one-word frame 10
// words are taken into a 4-entry queue while bytes of earlier words are still going out
// reset is asynchronous, active low; it clears the queue, the frame state and the registers
// a stall on the byte side fills the queue, after which word_stall rises
`default_nettype none

module word_frame_sum_add_check_encoder_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        word_valid,
    output logic                             word_stall,
    input  wire wfs_pkg::wfs_in_t            word_data,
    output logic                             byte_valid,
    input  wire logic                        byte_stall,
    output wfs_pkg::wfs_out_t                byte_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [wfs_pkg::APB_AW-1:0]  paddr,
    input  wire logic [wfs_pkg::APB_DW-1:0]  pwdata,
    output logic [wfs_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);

    wfs_pkg::wfs_cfg_t   cfg_reg;
    wfs_pkg::wfs_cmd_t   push_cmd;
    wfs_pkg::wfs_cmd_t   head;
    wfs_pkg::wfs_qstat_t qstat;
    logic                push;
    logic                pop;
    logic                cfg_write;
    logic [1:0]          reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte    <= wfs_pkg::HEADER_RESET;
            cfg_reg.target_address <= wfs_pkg::ADDRESS_RESET;
            cfg_reg.frame_function <= wfs_pkg::FUNCTION_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                wfs_pkg::REG_HEADER:   cfg_reg.header_byte    <= pwdata[7:0];
                wfs_pkg::REG_ADDRESS:  cfg_reg.target_address <= pwdata[7:0];
                wfs_pkg::REG_FUNCTION: cfg_reg.frame_function <= pwdata[7:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            wfs_pkg::REG_HEADER:   prdata = {24'd0, cfg_reg.header_byte};
            wfs_pkg::REG_ADDRESS:  prdata = {24'd0, cfg_reg.target_address};
            wfs_pkg::REG_FUNCTION: prdata = {24'd0, cfg_reg.frame_function};
            default:               prdata = '0;
        endcase
    end

    wfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word_data  (word_data),
        .cfg        (cfg_reg),
        .qstat      (qstat),
        .push       (push),
        .cmd        (push_cmd)
    );

    wfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    wfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("queue read while empty");

    a_end_then_open: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && byte_data.frame_end && !byte_stall && !qstat.empty)
        |-> head.first)
        else $error("word after a finished frame does not open a new frame");

endmodule

`default_nettype wire
